FILE: rtl/ffd_pkg.sv
// ----------------------------------------------------------------------------
// ffd_pkg
// Shared types, constants and the FNV-1a byte step for the float field digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffd_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  localparam logic [7:0]  FNV_PRIME_LOW = 8'hb3;  // prime = 2^40 + 2^8 + 0xb3
  localparam logic [63:0] EXP_MASK  = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] SIGN_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_INF   = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] NEG_INF   = 64'hfff0_0000_0000_0000;
  // Order keys of the two infinities, the reset values of the marks
  localparam logic [63:0] POS_INF_KEY = 64'hfff0_0000_0000_0000;
  localparam logic [63:0] NEG_INF_KEY = 64'h0010_0000_0000_0000;
  localparam logic [31:0] COUNT_MAX = 32'hffff_ffff;

  // One classified sample as it travels from the front to the back
  typedef struct packed {
    logic [63:0] value_bits;
    logic        new_field;
    logic        nonfinite;
    logic [63:0] order_key;
  } item_t;

  // Fold one byte into the hash: xor, then multiply by the FNV prime mod 2^64
  function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x * FNV_PRIME_LOW);
  endfunction

endpackage

FILE: rtl/float_field_digest_unit.sv
// Flow: a pushed sample is written to a queue slot, then taken by the hash
// engine; its last byte is hashed, loading its transaction into the result
// ports, only once any earlier result is popped. The single FNV byte step
// (xor, multiply by the prime) hashes one sample's eight bytes in turn.
// Reset: synchronous rst empties the queue and result register and returns
// the digest to the offset basis, zero counts and infinite marks.
// ----------------------------------------------------------------------------
// float_field_digest_unit
// Running FNV-1a 64 digest with counts and min/max over raw IEEE doubles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module float_field_digest_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] value_bits,
  input  logic        new_field,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] running_hash,
  output logic [31:0] value_count,
  output logic [31:0] nonfinite_count,
  output logic        has_finite,
  output logic [63:0] min_bits,
  output logic [63:0] max_bits
);

  logic           q_valid;
  logic           q_take;
  ffd_pkg::item_t q_item;

  ffd_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .value_bits (value_bits),
    .new_field  (new_field),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_take     (q_take)
  );

  ffd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_take          (q_take),
    .empty           (empty),
    .pop             (pop),
    .running_hash    (running_hash),
    .value_count     (value_count),
    .nonfinite_count (nonfinite_count),
    .has_finite      (has_finite),
    .min_bits        (min_bits),
    .max_bits        (max_bits)
  );

endmodule

FILE: rtl/ffd_front.sv
// ----------------------------------------------------------------------------
// ffd_front
// Accepts samples, classifies them and buffers them for the hash engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffd_front #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [63:0]          value_bits,
  input  logic                 new_field,
  output logic                 q_valid,
  output ffd_pkg::item_t       q_item,
  input  logic                 q_take
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  ffd_pkg::item_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  q_count;
  logic           wr_en;
  logic           rd_en;
  ffd_pkg::item_t in_item;
  logic [62:0]    mag;

  assign full    = (q_count == CW'(DEPTH));
  assign q_valid = (q_count != '0);
  assign q_item  = slots[rd_ptr];
  assign wr_en   = push && !full;
  assign rd_en   = q_take && q_valid;

  // Classify: flag inf/NaN and map the pattern to an unsigned order key
  assign mag = value_bits[62:0];
  always_comb begin
    in_item.value_bits = value_bits;
    in_item.new_field  = new_field;
    in_item.nonfinite  = ((value_bits & ffd_pkg::EXP_MASK) == ffd_pkg::EXP_MASK);
    if (mag == '0) begin
      in_item.order_key = ffd_pkg::SIGN_BIT;
    end else if (value_bits[63]) begin
      in_item.order_key = ffd_pkg::SIGN_BIT - {1'b0, mag};
    end else begin
      in_item.order_key = ffd_pkg::SIGN_BIT + {1'b0, mag};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        q_count <= q_count + 1'b1;
      end else if (rd_en && !wr_en) begin
        q_count <= q_count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CW'(DEPTH))
    else $error("front queue count exceeds depth");

endmodule

FILE: rtl/ffd_back.sv
// ----------------------------------------------------------------------------
// ffd_back
// Hash engine, one byte per cycle unless stalled, statistics, result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ffd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  ffd_pkg::item_t       q_item,
  output logic                 q_take,
  output logic                 empty,
  input  logic                 pop,
  output logic [63:0]          running_hash,
  output logic [31:0]          value_count,
  output logic [31:0]          nonfinite_count,
  output logic                 has_finite,
  output logic [63:0]          min_bits,
  output logic [63:0]          max_bits
);

  logic        busy;
  logic [2:0]  idx;
  logic [63:0] data;
  logic [63:0] hash_acc;
  logic [31:0] total_seen, total_seen_next;
  logic [31:0] bad_seen, bad_seen_next;
  logic        any_finite, any_finite_next;
  logic [63:0] low_mark, low_mark_next;
  logic [63:0] high_mark, high_mark_next;
  logic [63:0] low_key, low_key_next;
  logic [63:0] high_key, high_key_next;
  logic        out_valid;
  logic [63:0] hash_step;
  logic        finishing;
  logic        advance;

  assign hash_step = ffd_pkg::fnv_step(hash_acc, data[7:0]);
  assign finishing = busy && (idx == 3'd7) && (!out_valid || pop);
  assign advance   = busy && ((idx != 3'd7) || finishing);
  assign q_take    = q_valid && (!busy || finishing);
  assign empty     = !out_valid;

  // Statistics for the sample being taken; restart first on new_field
  always_comb begin
    logic [31:0] t_base, b_base;
    logic        f_base;
    logic [63:0] lm_base, hm_base, lk_base, hk_base;
    t_base  = q_item.new_field ? '0 : total_seen;
    b_base  = q_item.new_field ? '0 : bad_seen;
    f_base  = q_item.new_field ? 1'b0 : any_finite;
    lm_base = q_item.new_field ? ffd_pkg::POS_INF : low_mark;
    hm_base = q_item.new_field ? ffd_pkg::NEG_INF : high_mark;
    lk_base = q_item.new_field ? ffd_pkg::POS_INF_KEY : low_key;
    hk_base = q_item.new_field ? ffd_pkg::NEG_INF_KEY : high_key;

    total_seen_next = (t_base == ffd_pkg::COUNT_MAX) ? t_base : t_base + 1'b1;
    bad_seen_next   = b_base;
    any_finite_next = f_base;
    low_mark_next   = lm_base;
    high_mark_next  = hm_base;
    low_key_next    = lk_base;
    high_key_next   = hk_base;
    if (q_item.nonfinite) begin
      bad_seen_next = (b_base == ffd_pkg::COUNT_MAX) ? b_base : b_base + 1'b1;
    end else begin
      any_finite_next = 1'b1;
      if (q_item.order_key < lk_base) begin
        low_mark_next = q_item.value_bits;
        low_key_next  = q_item.order_key;
      end
      if (q_item.order_key > hk_base) begin
        high_mark_next = q_item.value_bits;
        high_key_next  = q_item.order_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      idx        <= '0;
      hash_acc   <= ffd_pkg::FNV_BASIS;
      total_seen <= '0;
      bad_seen   <= '0;
      any_finite <= 1'b0;
      low_mark   <= ffd_pkg::POS_INF;
      high_mark  <= ffd_pkg::NEG_INF;
      low_key    <= ffd_pkg::POS_INF_KEY;
      high_key   <= ffd_pkg::NEG_INF_KEY;
    end else begin
      if (q_take) begin
        busy       <= 1'b1;
        idx        <= '0;
        data       <= q_item.value_bits;
        hash_acc   <= q_item.new_field ? ffd_pkg::FNV_BASIS
                    : (finishing ? hash_step : hash_acc);
        total_seen <= total_seen_next;
        bad_seen   <= bad_seen_next;
        any_finite <= any_finite_next;
        low_mark   <= low_mark_next;
        high_mark  <= high_mark_next;
        low_key    <= low_key_next;
        high_key   <= high_key_next;
      end else if (advance) begin
        // advance one byte, least significant first
        hash_acc <= hash_step;
        data     <= data >> 8;
        idx      <= idx + 1'b1;
        if (finishing) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Result register: load on the last byte, hold until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finishing) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finishing) begin
      running_hash    <= hash_step;
      value_count     <= total_seen;
      nonfinite_count <= bad_seen;
      has_finite      <= any_finite;
      min_bits        <= low_mark;
      max_bits        <= high_mark;
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pop |=> out_valid && $stable(running_hash) && $stable(value_count))
    else $error("waiting result overwritten");

  a_bad_le_total: assert property (@(posedge clk) disable iff (rst)
    bad_seen <= total_seen)
    else $error("nonfinite count exceeds total count");

  a_marks_ordered: assert property (@(posedge clk) disable iff (rst)
    any_finite |-> low_key <= high_key)
    else $error("minimum mark above maximum mark");

endmodule
